FILE: design/dmsc_pkg.sv
// ----------------------------------------------------------------------------
// dmsc_pkg: shared types and constants of the direct-mapped search cache
// Request, slot entry and result layouts, operation codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsc_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned MoveW    = 16;
  localparam int unsigned ValW     = 16;
  localparam int unsigned BoundW   = 2;
  localparam int unsigned AgeW     = 8;
  localparam int unsigned HalfW    = 7;
  localparam int unsigned FillW    = 10;
  localparam int unsigned FillProdW = 20;

  localparam int unsigned FillScale = 1000;   // fill count sample limit and scale
  localparam logic signed [ValW-1:0] HalfMaxS = 16'sd100;
  localparam logic [HalfW-1:0]       HalfMax  = 7'd100;

  localparam logic [BoundW-1:0] BOUND_NONE = 2'd0;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FILL  = 2'd3
  } op_e;

  // request after classification (halfmoves already clamped)
  typedef struct packed {
    op_e                      op;
    logic [KeyW-1:0]          key;
    logic [MoveW-1:0]         move;
    logic signed [ValW-1:0]   score;
    logic signed [ValW-1:0]   depth;
    logic [BoundW-1:0]        bound;
    logic [HalfW-1:0]         half;
  } item_t;

  // one slot of the table
  typedef struct packed {
    logic [KeyW-1:0]          key;
    logic [MoveW-1:0]         move;
    logic signed [ValW-1:0]   score;
    logic signed [ValW-1:0]   depth;
    logic [BoundW-1:0]        bound;
    logic [AgeW-1:0]          age;
    logic [HalfW-1:0]         half;
  } entry_t;

  typedef struct packed {
    logic                     hit;
    logic [MoveW-1:0]         move;
    logic signed [ValW-1:0]   score;
    logic signed [ValW-1:0]   depth;
    logic [BoundW-1:0]        bound;
    logic [AgeW-1:0]          age;
    logic [HalfW-1:0]         half;
    logic [FillW-1:0]         fill;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_FILL,
    ST_FILL_LAST,
    ST_FILL_OUT
  } back_state_e;

endpackage

`default_nettype wire

FILE: design/dmsc_front.sv
// ----------------------------------------------------------------------------
// dmsc_front: request intake
// Accepts requests, clamps the halfmove count and queues them (two deep).
// ----------------------------------------------------------------------------
`default_nettype none

module dmsc_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [1:0]             operation_i,
  input  wire logic [63:0]            position_key_i,
  input  wire logic [15:0]            best_move_i,
  input  wire logic signed [15:0]     score_value_i,
  input  wire logic signed [15:0]     search_depth_i,
  input  wire logic [1:0]             bound_kind_i,
  input  wire logic signed [15:0]     halfmove_count_i,
  input  wire logic                   init_busy_i,
  output dmsc_pkg::item_t             head_o,
  output logic                        head_valid_o,
  input  wire logic                   pop_i
);
  import dmsc_pkg::*;

  item_t       item_in;
  item_t       q_mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;

  // classify: clamp the fifty-move counter to 0..100
  always_comb begin
    item_in.op    = op_e'(operation_i);
    item_in.key   = position_key_i;
    item_in.move  = best_move_i;
    item_in.score = score_value_i;
    item_in.depth = search_depth_i;
    item_in.bound = bound_kind_i;
    if (halfmove_count_i < 16'sd0) begin
      item_in.half = '0;
    end else if (halfmove_count_i > HalfMaxS) begin
      item_in.half = HalfMax;
    end else begin
      item_in.half = halfmove_count_i[HalfW-1:0];
    end
  end

  assign busy_o       = init_busy_i || (cnt_q == 2'd2);
  assign push         = start_i && !busy_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/dmsc_back.sv
// ----------------------------------------------------------------------------
// dmsc_back: table sequencer
// Owns the slot memory; runs probe/store, clear sweeps and fill count walks.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsc_back #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [7:0]             cur_age_i,
  input  wire dmsc_pkg::item_t        head_i,
  input  wire logic                   head_valid_i,
  output logic                        pop_o,
  output logic                        init_busy_o,
  output logic                        res_valid_o,
  output dmsc_pkg::result_t           res_o
);
  import dmsc_pkg::*;

  localparam int unsigned Slots     = 1 << INDEX_BITS;
  localparam int unsigned Sample    = (Slots < FillScale) ? Slots : FillScale;
  localparam bit          SampleAll = (Slots >= FillScale);
  localparam logic [INDEX_BITS-1:0] SampleLast = INDEX_BITS'(Sample - 1);

  back_state_e state_q, state_d;

  entry_t      slot_mem [Slots];
  entry_t      rdata_q;
  item_t       cur_q;
  logic [INDEX_BITS-1:0] ctr_q;
  logic [FillW-1:0]      used_q;
  logic                  rvalid_q;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  entry_t                mem_wdata;
  logic                  mem_re;
  logic [INDEX_BITS-1:0] mem_raddr;

  result_t               res_d;
  logic                  res_valid_d;
  result_t               res_q;
  logic                  res_valid_q;

  logic                  clr_last;
  logic                  fill_last;
  logic                  key_match;
  logic                  replace;
  logic [FillProdW-1:0]  fill_prod;
  logic [FillW-1:0]      fill_val;

  assign clr_last  = (ctr_q == '1);
  assign fill_last = (ctr_q == SampleLast);
  assign key_match = (rdata_q.key == cur_q.key);
  assign replace   = (rdata_q.bound == BOUND_NONE) || key_match ||
                     ($signed(cur_q.depth) >= $signed(rdata_q.depth)) ||
                     (rdata_q.age != cur_age_i);

  // per mille: sample is 1000 (identity) or a power of two (shift)
  assign fill_prod = FillProdW'(used_q) * FillProdW'(FillScale);
  assign fill_val  = SampleAll ? used_q : FillW'(fill_prod >> INDEX_BITS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.op)
            OP_PROBE, OP_STORE: state_d = ST_EXEC;
            OP_CLEAR:           state_d = ST_CLEAR;
            OP_FILL:            state_d = ST_FILL;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC:      state_d = ST_IDLE;
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_FILL: begin
        if (fill_last) state_d = ST_FILL_LAST;
      end
      ST_FILL_LAST: state_d = ST_FILL_OUT;
      ST_FILL_OUT:  state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs, memory controls
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = ctr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = ctr_q;
    pop_o       = 1'b0;
    init_busy_o = 1'b0;
    res_valid_d = 1'b0;
    res_d       = '0;
    case (state_q)
      ST_INIT: begin
        init_busy_o = 1'b1;
        mem_we      = 1'b1;
      end
      ST_IDLE: begin
        pop_o     = head_valid_i;
        mem_re    = head_valid_i;
        mem_raddr = head_i.key[INDEX_BITS-1:0];
      end
      ST_EXEC: begin
        res_valid_d = 1'b1;
        mem_waddr   = cur_q.key[INDEX_BITS-1:0];
        if (cur_q.op == OP_PROBE) begin
          if ((rdata_q.bound != BOUND_NONE) && key_match) begin
            res_d.hit   = 1'b1;
            res_d.move  = rdata_q.move;
            res_d.score = rdata_q.score;
            res_d.depth = rdata_q.depth;
            res_d.bound = rdata_q.bound;
            res_d.age   = rdata_q.age;
            res_d.half  = rdata_q.half;
          end
        end else begin
          mem_we          = replace;
          mem_wdata.key   = cur_q.key;
          mem_wdata.move  = cur_q.move;
          mem_wdata.score = cur_q.score;
          mem_wdata.depth = cur_q.depth;
          mem_wdata.bound = cur_q.bound;
          mem_wdata.age   = cur_age_i;
          mem_wdata.half  = cur_q.half;
        end
      end
      ST_CLEAR: begin
        mem_we      = 1'b1;
        res_valid_d = clr_last;
      end
      ST_FILL: begin
        mem_re = 1'b1;
      end
      ST_FILL_LAST: begin
        res_valid_d = 1'b0;
      end
      ST_FILL_OUT: begin
        res_valid_d = 1'b1;
        res_d.fill  = fill_val;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ctr_q       <= '0;
      used_q      <= '0;
      rvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      rvalid_q    <= (state_q == ST_FILL);
      if (state_q == ST_IDLE) begin
        ctr_q  <= '0;
        used_q <= '0;
      end else begin
        if (state_q inside {ST_INIT, ST_CLEAR, ST_FILL}) begin
          ctr_q <= ctr_q + 1'b1;
        end
        if (rvalid_q && (rdata_q.bound != BOUND_NONE) && (rdata_q.age == cur_age_i)) begin
          used_q <= used_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    res_q <= res_d;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slot_mem[mem_raddr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: design/direct_mapped_search_cache_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_search_cache_top: direct-mapped search result cache
// Probe/store/clear/fill-count over a 2^INDEX_BITS slot table with
// depth/age replacement.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction  handshake
//  request   start_i, busy_o, operation_i..           in         start_i & !busy_o
//  result    result_valid_o, hit_o..fill_permille_o   out        one-cycle strobe
//  config    cfg_we_i, cfg_wdata_i                    in         write on cfg_we_i
//
//  Probe and store hold the sequencer for a registered slot read, then compare
//  and optional write. Clear sweeps all 2^INDEX_BITS slots and fill count reads
//  the first min(1000, 2^INDEX_BITS), one slot per cycle after the dispatch.
//  Results are registered, appearing in the cycle after the sequencer finishes,
//  and cannot be stalled. After reset the table is swept empty with busy_o
//  high; otherwise busy_o rises only when the two-deep request queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_search_cache_top #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [63:0]        position_key_i,
  input  wire logic [15:0]        best_move_i,
  input  wire logic signed [15:0] score_value_i,
  input  wire logic signed [15:0] search_depth_i,
  input  wire logic [1:0]         bound_kind_i,
  input  wire logic signed [15:0] halfmove_count_i,
  // config
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  // result
  output logic                    result_valid_o,
  output logic                    hit_o,
  output logic [15:0]             found_move_o,
  output logic signed [15:0]      found_score_o,
  output logic signed [15:0]      found_depth_o,
  output logic [1:0]              found_bound_o,
  output logic [7:0]              found_age_o,
  output logic [6:0]              found_halfmoves_o,
  output logic [9:0]              fill_permille_o
);
  import dmsc_pkg::*;

  item_t       head;
  logic        head_valid;
  logic        pop;
  logic        init_busy;
  result_t     res;
  logic        res_valid;
  logic [AgeW-1:0] cur_age_q;

  // current search generation; it must be written only while idle, by the user: the block leaves this unenforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_age_q <= '0;
    end else if (cfg_we_i) begin
      cur_age_q <= cfg_wdata_i;
    end
  end

  // intake: clamp and queue requests
  dmsc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .position_key_i  (position_key_i),
    .best_move_i     (best_move_i),
    .score_value_i   (score_value_i),
    .search_depth_i  (search_depth_i),
    .bound_kind_i    (bound_kind_i),
    .halfmove_count_i(halfmove_count_i),
    .init_busy_i     (init_busy),
    .head_o          (head),
    .head_valid_o    (head_valid),
    .pop_i           (pop)
  );

  // sequencer with the slot memory
  dmsc_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cur_age_i   (cur_age_q),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign result_valid_o    = res_valid;
  assign hit_o             = res.hit;
  assign found_move_o      = res.move;
  assign found_score_o     = res.score;
  assign found_depth_o     = res.depth;
  assign found_bound_o     = res.bound;
  assign found_age_o       = res.age;
  assign found_halfmoves_o = res.half;
  assign fill_permille_o   = res.fill;

endmodule

`default_nettype wire

FILE: bench/search_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_cache_checker: result predictor and scoreboard for the search cache
// Watches the request, config and result channels, keeps its own copy of the
// slot table and current age, and compares every result with the oldest
// expectation in order.
// ----------------------------------------------------------------------------
module search_cache_checker #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         operation_i,
  input  logic [63:0]        position_key_i,
  input  logic [15:0]        best_move_i,
  input  logic signed [15:0] score_value_i,
  input  logic signed [15:0] search_depth_i,
  input  logic [1:0]         bound_kind_i,
  input  logic signed [15:0] halfmove_count_i,
  // config channel
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  // result channel
  input  logic               result_valid_i,
  input  logic               hit_i,
  input  logic [15:0]        found_move_i,
  input  logic signed [15:0] found_score_i,
  input  logic signed [15:0] found_depth_i,
  input  logic [1:0]         found_bound_i,
  input  logic [7:0]         found_age_i,
  input  logic [6:0]         found_halfmoves_i,
  input  logic [9:0]         fill_permille_i,
  // status
  output int                 fail_count_o,
  output int                 open_count_o
);
  import dmsc_pkg::*;

  localparam int unsigned SlotCount   = 1 << INDEX_BITS;
  localparam int unsigned SampleCount = (SlotCount < FillScale) ? SlotCount : FillScale;

  entry_t          slot_q [SlotCount];
  logic [AgeW-1:0] age_q;
  result_t         expected_q [$];
  int              fail_count;
  int              open_count;

  assign fail_count_o = fail_count;
  assign open_count_o = open_count;

  // Applies one request to the table copy and returns the result it causes.
  function automatic result_t serve_request(
    input op_e                op,
    input logic [63:0]        key,
    input logic [15:0]        move,
    input logic signed [15:0] score,
    input logic signed [15:0] depth,
    input logic [1:0]         bound,
    input logic signed [15:0] halfmoves
  );
    result_t     res;
    entry_t      slot;
    int unsigned idx;
    int unsigned used;
    res  = '0;
    idx  = 32'(key[INDEX_BITS-1:0]);
    slot = slot_q[idx];
    case (op)
      OP_PROBE: begin
        if (slot.bound != BOUND_NONE && slot.key == key) begin
          res.hit   = 1'b1;
          res.move  = slot.move;
          res.score = slot.score;
          res.depth = slot.depth;
          res.bound = slot.bound;
          res.age   = slot.age;
          res.half  = slot.half;
        end
      end
      OP_STORE: begin
        if (slot.bound == BOUND_NONE || slot.key == key ||
            $signed(depth) >= $signed(slot.depth) || slot.age != age_q) begin
          slot.key   = key;
          slot.move  = move;
          slot.score = score;
          slot.depth = depth;
          slot.bound = bound;
          slot.age   = age_q;
          if (halfmoves < 0) begin
            slot.half = '0;
          end else if (halfmoves > HalfMaxS) begin
            slot.half = HalfMax;
          end else begin
            slot.half = halfmoves[HalfW-1:0];
          end
          slot_q[idx] = slot;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SlotCount; i++) slot_q[i] = '0;
      end
      default: begin
        used = 0;
        for (int i = 0; i < SampleCount; i++) begin
          if (slot_q[i].bound != BOUND_NONE && slot_q[i].age == age_q) used++;
        end
        res.fill = FillW'(used * FillScale / SampleCount);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    int      delta;
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) slot_q[i] = '0;
      age_q = '0;
      expected_q.delete();
      fail_count = 0;
      open_count <= 0;
    end else begin
      delta = 0;
      // results first: a request taken at this edge cannot answer at it
      if (result_valid_i) begin
        got = {hit_i, found_move_i, found_score_i, found_depth_i, found_bound_i,
               found_age_i, found_halfmoves_i, fill_permille_i};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with nothing pending: hit=%0b fill=%0d",
                     $realtime, hit_i, fill_permille_i);
          end
        end else begin
          want = expected_q.pop_front();
          delta--;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch exp hit=%0b move=%h score=%0d depth=%0d",
                       $realtime, want.hit, want.move, $signed(want.score),
                       $signed(want.depth));
              $display("%0t:          exp bound=%0d age=%0d half=%0d fill=%0d",
                       $realtime, want.bound, want.age, want.half, want.fill);
              $display("%0t:          got hit=%0b move=%h score=%0d depth=%0d",
                       $realtime, got.hit, got.move, $signed(got.score),
                       $signed(got.depth));
              $display("%0t:          got bound=%0d age=%0d half=%0d fill=%0d",
                       $realtime, got.bound, got.age, got.half, got.fill);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(serve_request(op_e'(operation_i), position_key_i, best_move_i,
                                           score_value_i, search_depth_i, bound_kind_i,
                                           halfmove_count_i));
        delta++;
      end
      if (cfg_we_i) age_q = cfg_wdata_i;
      open_count <= open_count + delta;
    end
  end

endmodule

FILE: bench/tb_direct_mapped_search_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_search_cache_top: testbench of the direct-mapped search cache
// Directed probes/stores around replacement, empty-bound and halfmove clamp
// corners, then bursty random traffic over a small key pool with colliding
// slots, in phases at different ages. The checker predicts and scores.
// ----------------------------------------------------------------------------
module tb_direct_mapped_search_cache_top;
  import dmsc_pkg::*;

  localparam int unsigned IndexBits = 10;
  localparam int          CycleLimit = 1_000_000;   // far above a clean run
  localparam int          PhaseCount = 5;
  localparam int          PhaseItems = 245;
  localparam int          PoolSize   = 48;

  localparam logic [1:0] BOUND_EXACT = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [1:0] BOUND_UPPER = 2'd3;

  // keys used by the directed part; the first two share slot 5
  localparam logic [63:0] KeyA   = 64'h0123_4567_89AB_C005;
  localparam logic [63:0] KeyB   = 64'hFEDC_BA98_7654_3005;
  localparam logic [63:0] KeyC   = 64'h8000_0000_0000_0007;
  localparam logic [63:0] KeyTop = 64'hFFFF_FFFF_FFFF_FFFF;  // last slot, outside fill sample

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         operation_i = '0;
  logic [63:0]        position_key_i = '0;
  logic [15:0]        best_move_i = '0;
  logic signed [15:0] score_value_i = '0;
  logic signed [15:0] search_depth_i = '0;
  logic [1:0]         bound_kind_i = '0;
  logic signed [15:0] halfmove_count_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [7:0]         cfg_wdata_i = '0;
  logic               result_valid_o;
  logic               hit_o;
  logic [15:0]        found_move_o;
  logic signed [15:0] found_score_o;
  logic signed [15:0] found_depth_o;
  logic [1:0]         found_bound_o;
  logic [7:0]         found_age_o;
  logic [6:0]         found_halfmoves_o;
  logic [9:0]         fill_permille_o;

  int fail_count;
  int open_count;
  int cycle_count = 0;

  // key pool: half the keys land on a few hot slots so stores collide and
  // the depth/age replacement rule gets exercised; the rest spread out
  logic [63:0]          key_pool [PoolSize];
  logic [IndexBits-1:0] hot_slot [6];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  direct_mapped_search_cache_top #(
    .INDEX_BITS(IndexBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .position_key_i   (position_key_i),
    .best_move_i      (best_move_i),
    .score_value_i    (score_value_i),
    .search_depth_i   (search_depth_i),
    .bound_kind_i     (bound_kind_i),
    .halfmove_count_i (halfmove_count_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .hit_o            (hit_o),
    .found_move_o     (found_move_o),
    .found_score_o    (found_score_o),
    .found_depth_o    (found_depth_o),
    .found_bound_o    (found_bound_o),
    .found_age_o      (found_age_o),
    .found_halfmoves_o(found_halfmoves_o),
    .fill_permille_o  (fill_permille_o)
  );

  search_cache_checker #(
    .INDEX_BITS(IndexBits)
  ) cache_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .operation_i      (operation_i),
    .position_key_i   (position_key_i),
    .best_move_i      (best_move_i),
    .score_value_i    (score_value_i),
    .search_depth_i   (search_depth_i),
    .bound_kind_i     (bound_kind_i),
    .halfmove_count_i (halfmove_count_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_i   (result_valid_o),
    .hit_i            (hit_o),
    .found_move_i     (found_move_o),
    .found_score_i    (found_score_o),
    .found_depth_i    (found_depth_o),
    .found_bound_i    (found_bound_o),
    .found_age_i      (found_age_o),
    .found_halfmoves_i(found_halfmoves_o),
    .fill_permille_i  (fill_permille_o),
    .fail_count_o     (fail_count),
    .open_count_o     (open_count)
  );

  // Drives one request and returns at the edge where it is taken. start_i
  // stays high, so a following request rides straight on.
  task automatic send_request(input op_e op, input logic [63:0] key,
                              input logic [15:0] move, input logic [15:0] score,
                              input logic [15:0] depth, input logic [1:0] bound,
                              input logic [15:0] halfmoves);
    start_i          <= 1'b1;
    operation_i      <= op;
    position_key_i   <= key;
    best_move_i      <= move;
    score_value_i    <= score;
    search_depth_i   <= depth;
    bound_kind_i     <= bound;
    halfmove_count_i <= halfmoves;
    do @(posedge clk_i); while (busy_o);
  endtask

  // sender gap; a gap of zero leaves start_i alone
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // every request answers once, so an empty scoreboard means the block is idle
  task automatic wait_all_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
  endtask

  task automatic write_age(input logic [7:0] age);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= age;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly probes and stores over the pool; clear and fill count are rare
  // since each walks the table (the fill count only its sampled slots).
  task automatic send_random_request();
    op_e         op;
    logic [63:0] key;
    logic [15:0] depth;
    logic [15:0] halfmoves;
    logic [1:0]  bound;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 46) begin
      op = OP_PROBE;
    end else if (pick < 95) begin
      op = OP_STORE;
    end else if (pick < 96) begin
      op = OP_CLEAR;
    end else begin
      op = OP_FILL;
    end
    if ($urandom_range(0, 9) < 7) begin
      key = key_pool[$urandom_range(0, PoolSize - 1)];
    end else begin
      key = {$urandom, $urandom};
    end
    // small depths make ties and both sides of the compare common
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      depth = 16'($urandom_range(0, 24));
    end else if (pick < 7) begin
      depth = 16'(0 - $urandom_range(1, 8));
    end else begin
      depth = 16'($urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      halfmoves = 16'($urandom_range(0, 100));
    end else if (pick < 8) begin
      halfmoves = 16'($urandom_range(96, 104));   // around the clamp
    end else begin
      halfmoves = 16'($urandom);
    end
    bound = ($urandom_range(0, 9) == 0) ? BOUND_NONE : 2'($urandom_range(1, 3));
    send_request(op, key, 16'($urandom), 16'($urandom), depth, bound, halfmoves);
  endtask

  // hard stop if the block hangs
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    int         sent;
    int         burst;
    int         pick;
    logic [7:0] phase_age [PhaseCount];

    hot_slot[0] = IndexBits'(0);
    hot_slot[1] = IndexBits'(5);
    hot_slot[2] = IndexBits'(999);     // last sampled slot
    hot_slot[3] = IndexBits'(1000);    // first slot past the fill sample
    hot_slot[4] = '1;
    hot_slot[5] = IndexBits'($urandom);
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i % 2 == 0) key_pool[i][IndexBits-1:0] = hot_slot[(i / 2) % 6];
    end
    phase_age[0] = 8'd0;
    phase_age[1] = 8'd1;
    phase_age[2] = 8'($urandom);
    phase_age[3] = 8'd255;
    phase_age[4] = 8'($urandom);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the table sweep after reset holds busy_o high
    do @(posedge clk_i); while (busy_o);
    write_age(8'd0);

    // ---- directed: empty table, replacement rule, clamp, empty bound ----
    send_request(OP_PROBE, 64'd0, '0, '0, '0, BOUND_NONE, '0);              // miss on empty
    send_request(OP_FILL, '0, '0, '0, '0, BOUND_NONE, '0);                  // zero fill
    send_request(OP_STORE, KeyA, 16'hFFFF, 16'h8000, 16'h7FFF, BOUND_EXACT,
                 16'hFFFB);                                                  // negative halfmoves
    send_request(OP_PROBE, KeyA, '0, '0, '0, BOUND_NONE, '0);
    // same slot, other key, shallower, same age: entry must survive
    send_request(OP_STORE, KeyB, 16'h1234, 16'h0001, 16'h8000, BOUND_LOWER, 16'd50);
    send_request(OP_PROBE, KeyB, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_PROBE, KeyA, '0, '0, '0, BOUND_NONE, '0);
    // equal depth wins, halfmoves clamp at the top
    send_request(OP_STORE, KeyB, 16'h5678, 16'h7FFF, 16'h7FFF, BOUND_LOWER, 16'd200);
    send_request(OP_PROBE, KeyB, '0, '0, '0, BOUND_NONE, '0);
    // matching key overwrites even at the lowest depth
    send_request(OP_STORE, KeyB, 16'h0000, 16'h7FFF, 16'h8000, BOUND_UPPER, 16'd100);
    send_request(OP_PROBE, KeyB, '0, '0, '0, BOUND_NONE, '0);
    // a store with no bound leaves the slot empty
    send_request(OP_STORE, KeyC, 16'hAAAA, 16'h5555, 16'd3, BOUND_NONE, 16'd7);
    send_request(OP_PROBE, KeyC, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_STORE, KeyTop, 16'hFFFF, 16'hFFFF, 16'hFFFF, BOUND_EXACT, 16'd0);
    send_request(OP_PROBE, KeyTop, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_FILL, '0, '0, '0, '0, BOUND_NONE, '0);                  // slot 5 only
    wait_all_results();
    write_age(8'd255);
    // stale age: even the shallowest store replaces
    send_request(OP_STORE, KeyA, 16'h0F0F, 16'hF0F0, 16'h8000, BOUND_EXACT, 16'd101);
    send_request(OP_PROBE, KeyA, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_FILL, '0, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_CLEAR, '0, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_PROBE, KeyA, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_FILL, '0, '0, '0, '0, BOUND_NONE, '0);
    send_request(OP_PROBE, KeyTop, '0, '0, '0, BOUND_NONE, '0);

    // ---- random phases, each at its own age, drained before the write ----
    for (int p = 0; p < PhaseCount; p++) begin
      wait_all_results();
      write_age(phase_age[p]);
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PhaseItems; k++) begin
          send_random_request();
          sent++;
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          hold_off(0);                           // back-to-back bursts
        end else if (pick < 9) begin
          hold_off($urandom_range(1, 6));
        end else begin
          hold_off($urandom_range(20, 40));
        end
      end
    end

    wait_all_results();
    // idle on to catch any stray strobe
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
